// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the mapper RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: src/rbscm_pkg.sv
// ----------------------------------------------------------------------------
// rbscm_pkg
// Types and constants of the banked-RAM sound cartridge mapper.
// ----------------------------------------------------------------------------
package rbscm_pkg;

  localparam int FA_W = 17;  // RAM address space of the mapper

  // address[15:11] window codes
  localparam logic [4:0] WIN_SND_OLD_EN = 5'b10010;  // $9000-$97ff
  localparam logic [4:0] WIN_SND_OLD    = 5'b10011;  // $9800-$9fff
  localparam logic [4:0] WIN_SND_NEW_EN = 5'b10110;  // $b000-$b7ff
  localparam logic [4:0] WIN_SND_NEW    = 5'b10111;  // $b800-$bfff

  localparam logic [14:0] MODE_REG_ADDR = 15'h5fff;  // address[15:1] of $bffe/$bfff

  localparam logic [0:0] CFG_RAM_LAYOUT = 1'b0;
  localparam logic [0:0] CFG_UNMAPPED   = 1'b1;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_OLD  = 2'd1,
    TGT_NEW  = 2'd2
  } target_t;

  // item in flight between RAM issue and the output register
  typedef struct packed {
    target_t     target;
    logic        is_write;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        from_ram;
    logic        unmapped;
  } stage_t;

endpackage

// File: src/rbscm_ram.sv
// ----------------------------------------------------------------------------
// rbscm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rbscm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/ram_bank_sound_cartridge_mapper.sv
// ----------------------------------------------------------------------------
// ram_bank_sound_cartridge_mapper
// Cartridge mapper: four bank registers, mode and sound-enable registers,
// banked RAM, sound window decode for an external sound chip.
// ----------------------------------------------------------------------------
// Path: from accept, an item passes the RAM read stage and then the output register.
// Throughput: one item per cycle while no clearing pass runs and the output is not
//   held by m_tready; register updates and RAM writes take effect at the accept edge,
//   so the next item sees them with no stall. Reset: rst resets the control registers,
//   then a clearing pass zeroes the RAM, one byte a cycle over all RAM_BYTES addresses,
//   while s_tready stays low. Configuration writes are taken during the pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ram_bank_sound_cartridge_mapper #(
  parameter int RAM_BYTES = 131072
) (
  input  logic        clk,
  input  logic        rst,
  // access items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
  input  logic        s_tuser,   // [0] req_type (1 write)
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] read_data, [23:8] sound_addr, [31:24] sound_data
  output logic [2:0]  m_tuser,   // [1:0] sound_target, [2] sound_write
  // configuration
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int AW = $clog2(RAM_BYTES);

  // configuration
  logic [1:0] ram_layout;
  logic [7:0] unmapped_value;

  // mapper state
  logic [7:0] mode_reg;
  logic [3:0] bank_number [4];
  logic [3:0] bank_write_enable;
  logic [1:0] sound_enable_bits;

  // RAM clearing pass
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // pipeline
  rbscm_pkg::stage_t s1, s1_next;
  logic              s1_valid;
  logic              s1_move;
  logic              s_accept;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  // ---------------------------------------------------------------- decode
  logic        is_write;
  logic [15:0] a;
  logic [7:0]  v;
  logic [4:0]  win;
  logic [1:0]  slot;
  logic [rbscm_pkg::FA_W-1:0] fa;
  logic        present;
  logic        in_range;
  logic        mode_wr;
  logic        old_on;
  logic        new_on;
  logic        bank_wr;
  logic        item_ram_we;

  assign is_write = s_tuser;
  assign a        = s_tdata[15:0];
  assign v        = s_tdata[23:16];
  assign win      = a[15:11];
  // page-2 modulo 4; the mirrored pages only differ in address bit 15
  assign slot     = {~a[14], a[13]};
  assign fa       = {bank_number[slot], a[12:0]};
  assign present  = (fa[16] ? ram_layout[1] : ram_layout[0]) &&
                    ({1'b0, fa} < (rbscm_pkg::FA_W + 1)'(RAM_BYTES));
  assign in_range = (a[15:14] == 2'b01) || (a[15:14] == 2'b10);
  assign mode_wr  = (a[15:1] == rbscm_pkg::MODE_REG_ADDR);
  assign old_on   = sound_enable_bits[0] && !mode_reg[5];
  assign new_on   = sound_enable_bits[1] && mode_reg[5];

  // write that misses the RAM: sound-enable, sound window, bank registers
  assign bank_wr     = is_write && in_range && !mode_wr && !bank_write_enable[slot];
  assign item_ram_we = is_write && in_range && !mode_wr && bank_write_enable[slot] && present;

  always_comb begin
    s1_next          = '0;
    s1_next.target   = rbscm_pkg::TGT_NONE;
    s1_next.is_write = is_write;
    s1_next.addr     = a;
    s1_next.data     = v;
    if (!is_write) begin
      if (win == rbscm_pkg::WIN_SND_OLD && old_on) begin
        s1_next.target = rbscm_pkg::TGT_OLD;
      end else if (win == rbscm_pkg::WIN_SND_NEW && new_on) begin
        s1_next.target = rbscm_pkg::TGT_NEW;
      end else begin
        s1_next.from_ram = present;
        s1_next.unmapped = !present;
      end
    end else if (bank_wr) begin
      if (win == rbscm_pkg::WIN_SND_OLD && old_on) begin
        s1_next.target = rbscm_pkg::TGT_OLD;
      end else if (win == rbscm_pkg::WIN_SND_NEW && new_on) begin
        s1_next.target = rbscm_pkg::TGT_NEW;
      end
    end
  end

  // ------------------------------------------------------------ handshake
  assign s1_move  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !clearing && (!s1_valid || s1_move);
  assign s_accept = s_tvalid && s_tready;

  // ------------------------------------------------------------ RAM access
  assign ram_we    = clearing || (s_accept && item_ram_we);
  assign ram_waddr = clearing ? clr_addr : fa[AW-1:0];
  assign ram_wdata = clearing ? 8'h00 : v;

  rbscm_ram #(
    .WIDTH (8),
    .DEPTH (RAM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (s_accept),
    .raddr (fa[AW-1:0]),
    .rdata (ram_rdata)
  );

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(RAM_BYTES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_layout     <= 2'd3;
      unmapped_value <= 8'hff;
    end else if (cfg_we) begin
      case (cfg_index)
        rbscm_pkg::CFG_RAM_LAYOUT: ram_layout     <= cfg_data[1:0];
        rbscm_pkg::CFG_UNMAPPED:   unmapped_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // mapper registers, updated at the accept edge
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg          <= '0;
      bank_write_enable <= '0;
      sound_enable_bits <= '0;
      for (int i = 0; i < 4; i++) begin
        bank_number[i] <= 4'(i);
      end
    end else if (s_accept && is_write && in_range) begin
      if (mode_wr) begin
        mode_reg             <= v;
        bank_write_enable[0] <= v[0] | v[4];
        bank_write_enable[1] <= v[1] | v[4];
        bank_write_enable[2] <= v[4] | (v[2] & v[5]);
        bank_write_enable[3] <= v[4];
      end else if (bank_wr) begin
        if (win == rbscm_pkg::WIN_SND_OLD_EN) begin
          sound_enable_bits[0] <= (v[5:0] == 6'h3f);
        end
        if (win == rbscm_pkg::WIN_SND_NEW_EN) begin
          sound_enable_bits[1] <= v[7];
        end
        if (a[12:11] == 2'b10) begin
          bank_number[slot] <= v[3:0];
        end
      end
    end
  end

  // ------------------------------------------------------------ stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1 <= s1_next;
    end
  end

  // ------------------------------------------------------------ output
  logic [7:0] rd_sel;
  logic       fwd;

  assign fwd = (s1.target != rbscm_pkg::TGT_NONE);

  always_comb begin
    rd_sel = 8'h00;
    if (s1.from_ram) begin
      rd_sel = ram_rdata;
    end else if (s1.unmapped) begin
      rd_sel = unmapped_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_tdata[7:0]   <= rd_sel;
      m_tdata[23:8]  <= fwd ? s1.addr : 16'h0000;
      m_tdata[31:24] <= (fwd && s1.is_write) ? s1.data : 8'h00;
      m_tuser[1:0]   <= s1.target;
      m_tuser[2]     <= fwd && s1.is_write;
    end
  end

  // ------------------------------------------------------------ checks
  `ASSERT_IMPLIES(a_no_accept_clearing, clk, rst, clearing, !s_tready)
  `ASSERT_IMPLIES(a_ram_we_source, clk, rst, ram_we && !clearing, s_accept && is_write)
  `ASSERT_NEXT(a_accept_fills_s1, clk, rst, s_accept, s1_valid)
  `ASSERT_IMPLIES(a_no_fwd_no_addr, clk, rst,
                  m_tvalid && (m_tuser[1:0] == rbscm_pkg::TGT_NONE),
                  (m_tdata[23:8] == 16'h0000) && !m_tuser[2])

endmodule
